// File: rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the oscillator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mepo_pkg.sv
// Types, constants and the exponent step table of the multiphase oscillator.
package mepo_pkg;

   localparam int NUM_PHASES_DEF = 8;
   localparam int EXP_BITS       = 12;

   localparam logic [31:0]        HALF_CYCLE = 32'h8000_0000;
   localparam logic signed [19:0] PITCH_CAP  = 20'sd40960;
   localparam logic [15:0]        MAX16      = 16'hFFFF;
   localparam logic [30:0]        M_ONE      = 31'h4000_0000;

   localparam logic signed [16:0] BASE_PITCH_RST = -17'sd18432;
   localparam logic signed [16:0] CV_AMOUNT_RST  = 17'sd0;
   localparam logic [16:0]        SAW_LEVEL_RST  = 17'd65536;
   localparam logic [16:0]        TRI_LEVEL_RST  = 17'd65536;
   localparam logic [24:0]        UNIT_INC_RST   = 25'd97391;

   typedef enum logic [2:0] {
      CSR_BASE_PITCH = 3'd0,
      CSR_CV_AMOUNT  = 3'd1,
      CSR_SAW_LEVEL  = 3'd2,
      CSR_TRI_LEVEL  = 3'd3,
      CSR_UNIT_INC   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [16:0] base_pitch;
      logic signed [16:0] cv_amount;
      logic [16:0]        saw_level;
      logic [16:0]        tri_level;
      logic [24:0]        unit_increment;
   } cfg_type;

   typedef struct packed {
      logic add;
      logic rotate;
   } cell_ctrl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] inc;
   } inc_status_type;

   typedef enum logic [2:0] {
      INC_IDLE,
      INC_CV,
      INC_PITCH,
      INC_EXP,
      INC_SCALE,
      INC_SHIFT,
      INC_DONE
   } inc_state_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_CALC,
      SEQ_EMIT
   } seq_state_type;

   // Q30 factor 2^(2^b/4096) for each bit b of the pitch fraction.
   function automatic logic [30:0] exp_step(input logic [3:0] b);
      logic [30:0] v;
      case (b)
         4'd0:    v = 31'd1073923544;
         4'd1:    v = 31'd1074105294;
         4'd2:    v = 31'd1074468888;
         4'd3:    v = 31'd1075196443;
         4'd4:    v = 31'd1076653033;
         4'd5:    v = 31'd1079572136;
         4'd6:    v = 31'd1085434106;
         4'd7:    v = 31'd1097253708;
         4'd8:    v = 31'd1121280436;
         4'd9:    v = 31'd1170923762;
         4'd10:   v = 31'd1276901417;
         4'd11:   v = 31'd1518500250;
         default: v = M_ONE;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/mepo_if.sv
// Valid/ready channel interfaces for control voltage beats and phase result beats.
interface mepo_req_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] cv_volts;

   modport source (output valid, output cv_volts, input ready);
   modport sink (input valid, input cv_volts, output ready);
endinterface

interface mepo_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  phase_index;
   logic [15:0] saw_out;
   logic [15:0] tri_out;
   logic [15:0] brightness;
   logic        last_phase;

   modport source (output valid, output phase_index, output saw_out, output tri_out,
                   output brightness, output last_phase, input ready);
   modport sink (input valid, input phase_index, input saw_out, input tri_out,
                 input brightness, input last_phase, output ready);
endinterface

// File: rtl/multiphase_exp_pitch_oscillator.sv
// Multiphase exponential-pitch oscillator.
// The req channel takes one control voltage beat per sample tick. For each tick the
// block computes a phase increment from base pitch plus scaled CV, advances all
// NUM_PHASES phase accumulators and sends NUM_PHASES beats on the rsp channel, one
// per phase in index order, with last_phase set on the final beat.
// After the input beat is accepted, the increment unit computes the phase increment,
// the ring adds it and the first result beat is registered; the remaining beats
// follow one per cycle while rsp is ready. The increment unit uses a twelve-step
// serial exponent multiplier; the readout walks the accumulator ring one phase per beat.
// req.ready is high only while no tick is in progress.
// When the receiver stalls, the current beat holds in the output register and the
// ring stops rotating until it is taken.
// Reset loads phase k with k/NUM_PHASES of a cycle and the registers with their
// defaults. The csr port writes a register at any edge with csr_we high; writes
// are meant for idle periods only. Unknown register indices are ignored.
`include "assert_macros.svh"

module multiphase_exp_pitch_oscillator #(
   parameter int NUM_PHASES = mepo_pkg::NUM_PHASES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mepo_req_if.sink    req_ch,
   mepo_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);
   import mepo_pkg::*;

   localparam int          CNT_W      = $clog2(NUM_PHASES);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_PHASES - 1);
   localparam logic [2:0]  LAST_INDEX = 3'(NUM_PHASES - 1);

   cfg_type            cfg_ff;
   seq_state_type      seq_state_ff;
   seq_state_type      seq_state_in;
   logic [CNT_W-1:0]   emit_cnt_ff;
   logic               rsp_valid_ff;
   logic [2:0]         phase_index_ff;
   logic [15:0]        saw_out_ff;
   logic [15:0]        tri_out_ff;
   logic [15:0]        brightness_ff;
   logic               last_phase_ff;

   logic               req_take;
   logic               out_load;
   logic               emit_take;
   cell_ctrl_type      cell_ctrl;
   inc_status_type     inc_status;
   logic [31:0]        phase_w [NUM_PHASES];

   logic [31:0]        head;
   logic [15:0]        saw_raw;
   logic [32:0]        phase_dist;
   logic [16:0]        tri_raw;
   logic [17:0]        tri_diff;
   logic [32:0]        saw_prod;
   logic [33:0]        tri_prod;
   logic [15:0]        saw_sat;
   logic [15:0]        tri_sat;
   logic [15:0]        bright_sat;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_pitch     <= BASE_PITCH_RST;
         cfg_ff.cv_amount      <= CV_AMOUNT_RST;
         cfg_ff.saw_level      <= SAW_LEVEL_RST;
         cfg_ff.tri_level      <= TRI_LEVEL_RST;
         cfg_ff.unit_increment <= UNIT_INC_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_PITCH: cfg_ff.base_pitch     <= csr_wdata[16:0];
            CSR_CV_AMOUNT:  cfg_ff.cv_amount      <= csr_wdata[16:0];
            CSR_SAW_LEVEL:  cfg_ff.saw_level      <= csr_wdata[16:0];
            CSR_TRI_LEVEL:  cfg_ff.tri_level      <= csr_wdata[16:0];
            CSR_UNIT_INC:   cfg_ff.unit_increment <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mepo_incr_unit u_incr (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .start  (req_take),
      .cv     (req_ch.cv_volts),
      .status (inc_status)
   );

   // Cell 0 is the readout head; every cell takes the phase of the next one up.
   for (genvar k = 0; k < NUM_PHASES; k++) begin : g_cell
      localparam int          NEXT = (k + 1) % NUM_PHASES;
      localparam logic [31:0] RP   = 32'((64'(k) << 32) / NUM_PHASES);

      mepo_phase_cell #(
         .RESET_PHASE (RP)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (cell_ctrl),
         .inc            (inc_status.inc),
         .neighbor_phase (phase_w[NEXT]),
         .phase          (phase_w[k])
      );
   end

   // Sequencer.
   always_comb begin
      seq_state_in = seq_state_ff;
      case (seq_state_ff)
         SEQ_IDLE: if (req_ch.valid) seq_state_in = SEQ_CALC;
         SEQ_CALC: if (inc_status.done) seq_state_in = SEQ_EMIT;
         SEQ_EMIT: if (out_load && emit_cnt_ff == LAST_CNT) seq_state_in = SEQ_IDLE;
         default:  seq_state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready     = (seq_state_ff == SEQ_IDLE);
      req_take         = req_ch.valid && (seq_state_ff == SEQ_IDLE);
      out_load         = !rsp_valid_ff || rsp_ch.ready;
      emit_take        = (seq_state_ff == SEQ_EMIT) && out_load;
      cell_ctrl.add    = (seq_state_ff == SEQ_CALC) && inc_status.done;
      cell_ctrl.rotate = emit_take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff <= SEQ_IDLE;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_state_ff <= seq_state_in;
         if (emit_take) begin
            emit_cnt_ff <= (emit_cnt_ff == LAST_CNT) ? '0 : emit_cnt_ff + 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= emit_take;
         end
      end
   end

   // Waveforms of the phase at the head cell.
   always_comb begin
      head       = phase_w[0];
      saw_raw    = {~head[31], head[30:16]};
      phase_dist = head[31] ? (33'h1_0000_0000 - {1'b0, head}) : {1'b0, head};
      tri_diff   = 18'd65536 - phase_dist[32:15];
      tri_raw    = tri_diff[16:0];
      saw_prod   = 33'(saw_raw) * 33'(cfg_ff.saw_level);
      tri_prod   = 34'(tri_raw) * 34'(cfg_ff.tri_level);
      saw_sat    = (saw_prod[32:16] > 17'(MAX16)) ? MAX16 : saw_prod[31:16];
      tri_sat    = (tri_prod[33:16] > 18'(MAX16)) ? MAX16 : tri_prod[31:16];
      bright_sat = tri_raw[16] ? MAX16 : tri_raw[15:0];
   end

   always_ff @(posedge clock) begin
      if (emit_take) begin
         phase_index_ff <= 3'(emit_cnt_ff);
         saw_out_ff     <= saw_sat;
         tri_out_ff     <= tri_sat;
         brightness_ff  <= bright_sat;
         last_phase_ff  <= (emit_cnt_ff == LAST_CNT);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.phase_index = phase_index_ff;
   assign rsp_ch.saw_out     = saw_out_ff;
   assign rsp_ch.tri_out     = tri_out_ff;
   assign rsp_ch.brightness  = brightness_ff;
   assign rsp_ch.last_phase  = last_phase_ff;

   `ASSERT_IMPLY(a_last_index, clock, reset, rsp_ch.valid && rsp_ch.last_phase, rsp_ch.phase_index == LAST_INDEX, "last beat carries the wrong phase index")
   `ASSERT_IMPLY(a_inc_capped, clock, reset, inc_status.done, inc_status.inc <= HALF_CYCLE, "phase increment exceeds half a cycle")
   `ASSERT_NEXT(a_emit_after_done, clock, reset, inc_status.done, seq_state_ff == SEQ_EMIT, "readout did not start after the increment was ready")
   `ASSERT_IMPLY(a_idle_count, clock, reset, seq_state_ff == SEQ_IDLE, emit_cnt_ff == '0, "phase counter not at zero while idle")

endmodule

// File: rtl/mepo_phase_cell.sv
// One phase accumulator cell of the ring: adds the increment or takes its neighbor's phase.
module mepo_phase_cell #(
   parameter logic [31:0] RESET_PHASE = 32'h0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mepo_pkg::cell_ctrl_type ctrl,
   input  logic [31:0]            inc,
   input  logic [31:0]            neighbor_phase,
   output logic [31:0]            phase
);
   import mepo_pkg::*;

   logic [31:0] phase_ff;
   logic [31:0] phase_in;

   always_comb begin
      phase_in = phase_ff;
      if (ctrl.add) begin
         phase_in = phase_ff + inc;
      end else if (ctrl.rotate) begin
         phase_in = neighbor_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RESET_PHASE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign phase = phase_ff;

endmodule

// File: rtl/mepo_incr_unit.sv
// Turns one control voltage into a capped phase increment, one exponent bit per cycle.
module mepo_incr_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  mepo_pkg::cfg_type        cfg,
   input  logic                     start,
   input  logic signed [16:0]       cv,
   output mepo_pkg::inc_status_type status
);
   import mepo_pkg::*;

   inc_state_type      state_ff;
   inc_state_type      state_in;

   logic signed [16:0] cv_ff;
   logic signed [33:0] prod_ff;
   logic [11:0]        frac_ff;
   logic signed [7:0]  octave_ff;
   logic [30:0]        m_ff;
   logic [3:0]         bit_ff;
   logic [55:0]        scaled_ff;
   logic [31:0]        inc_ff;

   logic signed [18:0] cvterm;
   logic signed [19:0] pitch_sum;
   logic signed [19:0] pitch_cap;
   logic [62:0]        step_prod;
   logic [30:0]        m_rnd;
   logic [8:0]         shift_diff;
   logic [55:0]        shifted;
   logic [31:0]        inc_calc;

   always_comb begin
      // Floor of the CV product over 2^15 is an arithmetic shift.
      cvterm     = prod_ff[33:15];
      pitch_sum  = {{3{cfg.base_pitch[16]}}, cfg.base_pitch} + {cvterm[18], cvterm};
      pitch_cap  = (pitch_sum > PITCH_CAP) ? PITCH_CAP : pitch_sum;
      step_prod  = {1'b0, 62'(m_ff) * 62'(exp_step(bit_ff))} + 63'(32'h2000_0000);
      m_rnd      = step_prod[60:30];
      shift_diff = 9'd30 - {octave_ff[7], octave_ff};
      shifted    = scaled_ff >> shift_diff[7:0];
      inc_calc   = (shifted > 56'(HALF_CYCLE)) ? HALF_CYCLE : shifted[31:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         INC_IDLE:  if (start) state_in = INC_CV;
         INC_CV:    state_in = INC_PITCH;
         INC_PITCH: state_in = INC_EXP;
         INC_EXP:   if (bit_ff == 4'(EXP_BITS - 1)) state_in = INC_SCALE;
         INC_SCALE: state_in = INC_SHIFT;
         INC_SHIFT: state_in = INC_DONE;
         INC_DONE:  state_in = INC_IDLE;
         default:   state_in = INC_IDLE;
      endcase
   end

   always_comb begin
      status.done = (state_ff == INC_DONE);
      status.inc  = inc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= INC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         INC_IDLE: begin
            if (start) cv_ff <= cv;
         end
         INC_CV: begin
            prod_ff <= 34'(cfg.cv_amount) * 34'(cv_ff);
         end
         INC_PITCH: begin
            frac_ff   <= pitch_cap[11:0];
            octave_ff <= pitch_cap[19:12];
            m_ff      <= M_ONE;
            bit_ff    <= 4'd0;
         end
         INC_EXP: begin
            if (frac_ff[bit_ff]) m_ff <= m_rnd;
            bit_ff <= bit_ff + 4'd1;
         end
         INC_SCALE: begin
            scaled_ff <= 56'(cfg.unit_increment) * 56'(m_ff);
         end
         INC_SHIFT: begin
            inc_ff <= inc_calc;
         end
         default: begin
         end
      endcase
   end

endmodule
